// ----- rtl/core/hcb_pkg.sv -----
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and codes of the Huffman code builder: operations, result
// status codes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
package hcb_pkg;

    // Fixed widths of the item fields and of tree indexes, memory depths and alphabet size.
    localparam int SYM_W     = 8;
    localparam int IDX_W     = 9;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 9;
    localparam int CLEN_W    = 6;
    localparam int STAT_W    = 3;
    localparam int NODE_DEPTH = 511;
    localparam int HEAP_DEPTH = 256;
    localparam int STK_DEPTH  = 512;
    localparam int SYM_COUNT  = 256;

    // Node word: symbol, left child, right child.
    localparam int NODE_W = SYM_W + 2 * IDX_W;
    // Stack word: node index, code length, code bits.
    localparam int STK_W  = IDX_W + LEN_W + CODE_W;
    // Code table word: code bits, code length.
    localparam int CTAB_W = CODE_W + LEN_W;

    typedef enum logic [1:0] {
        OP_COUNT  = 2'd0,
        OP_BUILD  = 2'd1,
        OP_ENCODE = 2'd2,
        OP_DECODE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_NO_TREE  = 3'd4
    } t_status;

    // Where a heap extraction hands its top entry.
    typedef enum logic [1:0] {
        EX_FIRST  = 2'd0,
        EX_SECOND = 2'd1,
        EX_ROOT   = 2'd2
    } t_ex_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CNT_RD,
        S_ENC_RD,
        S_DEC_RD1,
        S_DEC_RD2,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_INS_TEST,
        S_INS_CMP,
        S_MRG_TEST,
        S_EX_RD0,
        S_EX_RDL,
        S_EX_LAST,
        S_SD_RDL,
        S_SD_RDR,
        S_SD_CMPR,
        S_SD_DEC,
        S_MRG_NODE,
        S_ROOT,
        S_DFS_POP,
        S_DFS_NODE,
        S_DFS_VISIT,
        S_DFS_PUSHL,
        S_DONE
    } t_state;

endpackage

// ----- rtl/core/hcb_ram.sv -----
// ----------------------------------------------------------------------------
// hcb_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered (old data on a collision).
// ----------------------------------------------------------------------------
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/huffman_code_builder_codec.sv -----
// ----------------------------------------------------------------------------
// huffman_code_builder_codec
// Byte-alphabet static Huffman engine: counts symbols, builds a Huffman tree
// through a min-heap, with its code table, encodes symbols and decodes bit by bit.
// ----------------------------------------------------------------------------
// Sequencing: count and encode results come from a single memory read;
// decode reads the current node and then its child, unless the tree is a
// single leaf. Build scans every symbol, sifts each insert up and each
// extract down the heap level by level, and walks the tree for the code table.
// Flow: one item at a time; the next item is accepted in the cycle after
// the result moves to the output register.
// Reset: control state clears at once; the histogram and the code table
// read as empty through per-entry valid bits, so no clearing pass is needed.
module huffman_code_builder_codec
    import hcb_pkg::*;
#(
    parameter int COUNT_WIDTH     = 24,
    parameter int MAX_CODE_LENGTH = 32,
    parameter int ALPHABET_SIZE   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_symbol,
    input  logic        i_code_bit,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_code_value,
    output logic [5:0]  o_code_length,
    output logic [7:0]  o_decoded_symbol,
    output logic        o_symbol_valid,
    output logic [2:0]  o_status
);

    // Heap keys carry weight, symbol and node index so ordering needs no
    // node lookups.
    localparam int WW    = COUNT_WIDTH + 8;
    localparam int KEY_W = WW + SYM_W + IDX_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [SYM_W-1:0]    r_sym, n_sym;
    logic                r_bit, n_bit;

    logic [IDX_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_used, n_used;
    logic [IDX_W-1:0]    r_nleaf, n_nleaf;
    logic [IDX_W-1:0]    r_s, n_s;
    logic [IDX_W-1:0]    r_root, n_root;
    logic                r_root_leaf, n_root_leaf;
    logic [SYM_W-1:0]    r_root_sym, n_root_sym;
    logic [IDX_W-1:0]    r_cursor, n_cursor;
    logic                r_tree, n_tree;
    logic                r_too_long, n_too_long;

    logic [KEY_W-1:0]    r_key, n_key;
    logic [KEY_W-1:0]    r_e, n_e;
    logic [KEY_W-1:0]    r_cand, n_cand;
    logic [KEY_W-1:0]    r_top, n_top;
    logic [KEY_W-1:0]    r_ka, n_ka;
    logic [IDX_W-1:0]    r_i, n_i;
    logic [IDX_W-1:0]    r_least, n_least;
    t_ex_sel             r_ex_sel, n_ex_sel;
    logic                r_ins_mrg, n_ins_mrg;

    logic [IDX_W-1:0]    r_sp, n_sp;
    logic [IDX_W-1:0]    r_dn, n_dn;
    logic [LEN_W-1:0]    r_dlen, n_dlen;
    logic [CODE_W-1:0]   r_dcode, n_dcode;

    logic [31:0]         r_res_cval, n_res_cval;
    logic [5:0]          r_res_clen, n_res_clen;
    logic [7:0]          r_res_dsym, n_res_dsym;
    logic                r_res_dval, n_res_dval;
    t_status             r_res_stat, n_res_stat;

    logic                r_out_valid;
    logic [31:0]         r_out_cval;
    logic [5:0]          r_out_clen;
    logic [7:0]          r_out_dsym;
    logic                r_out_dval;
    logic [2:0]          r_out_stat;

    logic [SYM_COUNT-1:0] r_hvalid;
    logic [SYM_COUNT-1:0] r_cvalid;

    // Valid bit controls.
    logic               hv_set;
    logic               cv_clr;
    logic               cv_set;
    logic [SYM_W-1:0]   cv_idx;
    logic               out_load;

    // RAM ports.
    logic                   hst_we;
    logic [SYM_W-1:0]       hst_waddr, hst_raddr;
    logic [COUNT_WIDTH-1:0] hst_wdata, hst_rdata;
    logic                   nod_we;
    logic [IDX_W-1:0]       nod_waddr, nod_raddr;
    logic [NODE_W-1:0]      nod_wdata, nod_rdata;
    logic                   hp_we;
    logic [7:0]             hp_waddr, hp_raddr;
    logic [KEY_W-1:0]       hp_wdata, hp_rdata;
    logic                   cod_we;
    logic [SYM_W-1:0]       cod_waddr, cod_raddr;
    logic [CTAB_W-1:0]      cod_wdata, cod_rdata;
    logic                   stk_we;
    logic [IDX_W-1:0]       stk_waddr, stk_raddr;
    logic [STK_W-1:0]       stk_wdata, stk_rdata;

    // Helper values.
    logic [COUNT_WIDTH-1:0] hist_val;
    logic [IDX_W:0]         child_l, child_r;
    logic [IDX_W-1:0]       parent;
    logic [IDX_W-1:0]       dec_child;
    logic [WW-1:0]          sum_w;

    function automatic logic key_less(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b);
        return a[KEY_W-1:IDX_W] < b[KEY_W-1:IDX_W];
    endfunction

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    hcb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(SYM_COUNT)) u_hist (
        .i_clk(i_clk), .i_we(hst_we), .i_waddr(hst_waddr), .i_wdata(hst_wdata),
        .i_raddr(hst_raddr), .o_rdata(hst_rdata)
    );

    hcb_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node (
        .i_clk(i_clk), .i_we(nod_we), .i_waddr(nod_waddr), .i_wdata(nod_wdata),
        .i_raddr(nod_raddr), .o_rdata(nod_rdata)
    );

    hcb_ram #(.WIDTH(KEY_W), .DEPTH(HEAP_DEPTH)) u_heap (
        .i_clk(i_clk), .i_we(hp_we), .i_waddr(hp_waddr), .i_wdata(hp_wdata),
        .i_raddr(hp_raddr), .o_rdata(hp_rdata)
    );

    hcb_ram #(.WIDTH(CTAB_W), .DEPTH(SYM_COUNT)) u_code (
        .i_clk(i_clk), .i_we(cod_we), .i_waddr(cod_waddr), .i_wdata(cod_wdata),
        .i_raddr(cod_raddr), .o_rdata(cod_rdata)
    );

    hcb_ram #(.WIDTH(STK_W), .DEPTH(STK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    assign hist_val  = r_hvalid[r_sym] ? hst_rdata : '0;
    assign child_l   = {r_i, 1'b1};
    assign child_r   = {r_i, 1'b0} + (IDX_W + 1)'(2);
    assign parent    = (r_i - IDX_W'(1)) >> 1;
    assign dec_child = r_bit ? nod_rdata[IDX_W-1:0] : nod_rdata[2*IDX_W-1:IDX_W];
    assign sum_w     = r_ka[KEY_W-1 -: WW] + r_top[KEY_W-1 -: WW];

    // ------------------------------------------------------------------
    // State and data registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_used      <= '0;
            r_nleaf     <= '0;
            r_root      <= '0;
            r_root_leaf <= 1'b0;
            r_cursor    <= '0;
            r_tree      <= 1'b0;
            r_too_long  <= 1'b0;
            r_sp        <= '0;
            r_ex_sel    <= EX_FIRST;
            r_ins_mrg   <= 1'b0;
            r_out_valid <= 1'b0;
            r_hvalid    <= '0;
            r_cvalid    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_used      <= n_used;
            r_nleaf     <= n_nleaf;
            r_root      <= n_root;
            r_root_leaf <= n_root_leaf;
            r_cursor    <= n_cursor;
            r_tree      <= n_tree;
            r_too_long  <= n_too_long;
            r_sp        <= n_sp;
            r_ex_sel    <= n_ex_sel;
            r_ins_mrg   <= n_ins_mrg;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (hv_set) begin
                r_hvalid[r_sym] <= 1'b1;
            end
            if (cv_clr) begin
                r_cvalid <= '0;
            end else if (cv_set) begin
                r_cvalid[cv_idx] <= 1'b1;
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_sym      <= n_sym;
        r_bit      <= n_bit;
        r_s        <= n_s;
        r_root_sym <= n_root_sym;
        r_key      <= n_key;
        r_e        <= n_e;
        r_cand     <= n_cand;
        r_top      <= n_top;
        r_ka       <= n_ka;
        r_i        <= n_i;
        r_least    <= n_least;
        r_dn       <= n_dn;
        r_dlen     <= n_dlen;
        r_dcode    <= n_dcode;
        r_res_cval <= n_res_cval;
        r_res_clen <= n_res_clen;
        r_res_dsym <= n_res_dsym;
        r_res_dval <= n_res_dval;
        r_res_stat <= n_res_stat;
        if (out_load) begin
            r_out_cval <= r_res_cval;
            r_out_clen <= r_res_clen;
            r_out_dsym <= r_res_dsym;
            r_out_dval <= r_res_dval;
            r_out_stat <= r_res_stat;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state, memory accesses and results
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sym       = r_sym;
        n_bit       = r_bit;
        n_count     = r_count;
        n_used      = r_used;
        n_nleaf     = r_nleaf;
        n_s         = r_s;
        n_root      = r_root;
        n_root_leaf = r_root_leaf;
        n_root_sym  = r_root_sym;
        n_cursor    = r_cursor;
        n_tree      = r_tree;
        n_too_long  = r_too_long;
        n_key       = r_key;
        n_e         = r_e;
        n_cand      = r_cand;
        n_top       = r_top;
        n_ka        = r_ka;
        n_i         = r_i;
        n_least     = r_least;
        n_ex_sel    = r_ex_sel;
        n_ins_mrg   = r_ins_mrg;
        n_sp        = r_sp;
        n_dn        = r_dn;
        n_dlen      = r_dlen;
        n_dcode     = r_dcode;
        n_res_cval  = r_res_cval;
        n_res_clen  = r_res_clen;
        n_res_dsym  = r_res_dsym;
        n_res_dval  = r_res_dval;
        n_res_stat  = r_res_stat;

        hv_set    = 1'b0;
        cv_clr    = 1'b0;
        cv_set    = 1'b0;
        cv_idx    = '0;
        out_load  = 1'b0;
        o_ready   = 1'b0;

        hst_we    = 1'b0;
        hst_waddr = r_sym;
        hst_wdata = hist_val + COUNT_WIDTH'(1);
        hst_raddr = r_sym;
        nod_we    = 1'b0;
        nod_waddr = r_used;
        nod_wdata = '0;
        nod_raddr = r_cursor;
        hp_we     = 1'b0;
        hp_waddr  = r_i[7:0];
        hp_wdata  = r_key;
        hp_raddr  = '0;
        cod_we    = 1'b0;
        cod_waddr = '0;
        cod_wdata = '0;
        cod_raddr = r_sym;
        stk_we    = 1'b0;
        stk_waddr = r_sp;
        stk_wdata = '0;
        stk_raddr = r_sp - IDX_W'(1);

        unique case (r_state)
            // Accept one item and start its operation.
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op       = t_op'(i_operation);
                    n_sym      = i_symbol;
                    n_bit      = i_code_bit;
                    n_res_cval = '0;
                    n_res_clen = '0;
                    n_res_dsym = '0;
                    n_res_dval = 1'b0;
                    n_res_stat = ST_OK;
                    hst_raddr  = i_symbol;
                    cod_raddr  = i_symbol;
                    unique case (t_op'(i_operation))
                        OP_COUNT: begin
                            if ({1'b0, i_symbol} >= IDX_W'(ALPHABET_SIZE)) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_CNT_RD;
                            end
                        end
                        OP_BUILD: begin
                            n_tree     = 1'b0;
                            n_count    = '0;
                            n_used     = '0;
                            n_s        = '0;
                            n_too_long = 1'b0;
                            cv_clr     = 1'b1;
                            n_state    = S_SCAN_RD;
                        end
                        OP_ENCODE: begin
                            if (!r_tree) begin
                                n_res_stat = ST_NO_TREE;
                                n_state    = S_DONE;
                            end else if ({1'b0, i_symbol} >= IDX_W'(ALPHABET_SIZE)) begin
                                n_res_stat = ST_EMPTY;
                                n_state    = S_DONE;
                            end else begin
                                n_state = S_ENC_RD;
                            end
                        end
                        OP_DECODE: begin
                            if (!r_tree) begin
                                n_res_stat = ST_NO_TREE;
                                n_state    = S_DONE;
                            end else if (r_root_leaf) begin
                                n_res_dsym = r_root_sym;
                                n_res_dval = 1'b1;
                                n_cursor   = r_root;
                                n_state    = S_DONE;
                            end else begin
                                n_state = S_DEC_RD1;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            // Count: saturating increment of the histogram entry.
            S_CNT_RD: begin
                if (hist_val == {COUNT_WIDTH{1'b1}}) begin
                    n_res_stat = ST_OVERFLOW;
                end else begin
                    hst_we = 1'b1;
                    hv_set = 1'b1;
                end
                n_state = S_DONE;
            end

            // Encode: look up the code table.
            S_ENC_RD: begin
                if (!r_cvalid[r_sym]) begin
                    n_res_stat = ST_EMPTY;
                end else begin
                    n_res_cval = cod_rdata[CTAB_W-1 -: CODE_W];
                    n_res_clen = cod_rdata[CLEN_W-1:0];
                end
                n_state = S_DONE;
            end

            // Decode: step to a child, then check whether it is a leaf.
            S_DEC_RD1: begin
                n_dn      = dec_child;
                nod_raddr = dec_child;
                n_state   = S_DEC_RD2;
            end

            S_DEC_RD2: begin
                if (r_dn < r_nleaf) begin
                    n_res_dsym = nod_rdata[NODE_W-1 -: SYM_W];
                    n_res_dval = 1'b1;
                    n_cursor   = r_root;
                end else begin
                    n_cursor = r_dn;
                end
                n_state = S_DONE;
            end

            // Build: scan the histogram in ascending symbol order.
            S_SCAN_RD: begin
                hst_raddr = r_s[SYM_W-1:0];
                if (r_s >= IDX_W'(ALPHABET_SIZE)) begin
                    n_nleaf = r_used;
                    if (r_count == '0) begin
                        n_res_stat = ST_EMPTY;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_MRG_TEST;
                    end
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK: begin
                if (r_hvalid[r_s[SYM_W-1:0]] && hst_rdata != '0) begin
                    nod_we    = 1'b1;
                    nod_waddr = r_used;
                    nod_wdata = {r_s[SYM_W-1:0], {(2 * IDX_W){1'b0}}};
                    n_key     = {WW'(hst_rdata), r_s[SYM_W-1:0], r_used};
                    n_i       = r_count;
                    n_count   = r_count + IDX_W'(1);
                    n_used    = r_used + IDX_W'(1);
                    n_ins_mrg = 1'b0;
                    n_state   = S_INS_TEST;
                end else begin
                    n_s     = r_s + IDX_W'(1);
                    n_state = S_SCAN_RD;
                end
            end

            // Heap insert: sift up from the new slot.
            S_INS_TEST: begin
                hp_raddr = parent[7:0];
                if (r_i == '0) begin
                    hp_we    = 1'b1;
                    hp_waddr = '0;
                    hp_wdata = r_key;
                    if (r_ins_mrg) begin
                        n_state = S_MRG_TEST;
                    end else begin
                        n_s     = r_s + IDX_W'(1);
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    n_state = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                hp_we    = 1'b1;
                hp_waddr = r_i[7:0];
                if (key_less(r_key, hp_rdata)) begin
                    hp_wdata = hp_rdata;
                    n_i      = parent;
                    n_state  = S_INS_TEST;
                end else begin
                    hp_wdata = r_key;
                    if (r_ins_mrg) begin
                        n_state = S_MRG_TEST;
                    end else begin
                        n_s     = r_s + IDX_W'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end

            // Merge loop: two minima while more than one entry remains and the node memory has room.
            S_MRG_TEST: begin
                if (r_count > IDX_W'(1) && r_used < IDX_W'(NODE_DEPTH)) begin
                    n_ex_sel = EX_FIRST;
                end else begin
                    n_ex_sel = EX_ROOT;
                end
                n_state = S_EX_RD0;
            end

            // Heap extract: take the top, move the last entry down.
            S_EX_RD0: begin
                hp_raddr = '0;
                n_state  = S_EX_RDL;
            end

            S_EX_RDL: begin
                n_top    = hp_rdata;
                n_count  = r_count - IDX_W'(1);
                hp_raddr = 8'(r_count - IDX_W'(1));
                n_state  = S_EX_LAST;
            end

            S_EX_LAST: begin
                n_e     = hp_rdata;
                n_i     = '0;
                n_state = S_SD_RDL;
            end

            S_SD_RDL: begin
                hp_raddr = child_l[7:0];
                if (child_l >= {1'b0, r_count}) begin
                    hp_we    = 1'b1;
                    hp_waddr = r_i[7:0];
                    hp_wdata = r_e;
                    unique case (r_ex_sel)
                        EX_FIRST: begin
                            n_ka     = r_top;
                            n_ex_sel = EX_SECOND;
                            n_state  = S_EX_RD0;
                        end
                        EX_SECOND: n_state = S_MRG_NODE;
                        default:   n_state = S_ROOT;
                    endcase
                end else begin
                    n_state = S_SD_RDR;
                end
            end

            S_SD_RDR: begin
                if (key_less(hp_rdata, r_e)) begin
                    n_least = child_l[IDX_W-1:0];
                    n_cand  = hp_rdata;
                end else begin
                    n_least = r_i;
                    n_cand  = r_e;
                end
                hp_raddr = child_r[7:0];
                if (child_r < {1'b0, r_count}) begin
                    n_state = S_SD_CMPR;
                end else begin
                    n_state = S_SD_DEC;
                end
            end

            S_SD_CMPR: begin
                if (key_less(hp_rdata, r_cand)) begin
                    n_least = child_r[IDX_W-1:0];
                    n_cand  = hp_rdata;
                end
                n_state = S_SD_DEC;
            end

            S_SD_DEC: begin
                hp_we    = 1'b1;
                hp_waddr = r_i[7:0];
                if (r_least == r_i) begin
                    hp_wdata = r_e;
                    unique case (r_ex_sel)
                        EX_FIRST: begin
                            n_ka     = r_top;
                            n_ex_sel = EX_SECOND;
                            n_state  = S_EX_RD0;
                        end
                        EX_SECOND: n_state = S_MRG_NODE;
                        default:   n_state = S_ROOT;
                    endcase
                end else begin
                    hp_wdata = r_cand;
                    n_i      = r_least;
                    n_state  = S_SD_RDL;
                end
            end

            // New internal node: first minimum left, second right.
            S_MRG_NODE: begin
                nod_we    = 1'b1;
                nod_waddr = r_used;
                nod_wdata = {{SYM_W{1'b0}}, r_ka[IDX_W-1:0], r_top[IDX_W-1:0]};
                n_key     = {sum_w, {SYM_W{1'b0}}, r_used};
                n_i       = r_count;
                n_count   = r_count + IDX_W'(1);
                n_used    = r_used + IDX_W'(1);
                n_ins_mrg = 1'b1;
                n_state   = S_INS_TEST;
            end

            // Root found: single leaf or start the code walk.
            S_ROOT: begin
                n_root      = r_top[IDX_W-1:0];
                n_cursor    = r_top[IDX_W-1:0];
                n_root_sym  = r_top[IDX_W +: SYM_W];
                n_root_leaf = r_top[IDX_W-1:0] < r_nleaf;
                if (r_top[IDX_W-1:0] < r_nleaf) begin
                    cod_we    = 1'b1;
                    cod_waddr = r_top[IDX_W +: SYM_W];
                    cod_wdata = {{CODE_W{1'b0}}, LEN_W'(1)};
                    cv_set    = 1'b1;
                    cv_idx    = r_top[IDX_W +: SYM_W];
                    n_tree    = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = {r_top[IDX_W-1:0], {LEN_W{1'b0}}, {CODE_W{1'b0}}};
                    n_sp      = IDX_W'(1);
                    n_state   = S_DFS_POP;
                end
            end

            // Depth-first walk, left subtree first.
            S_DFS_POP: begin
                if (r_sp == '0) begin
                    if (r_too_long) begin
                        n_res_stat = ST_TOO_LONG;
                    end else begin
                        n_tree = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_sp    = r_sp - IDX_W'(1);
                    n_state = S_DFS_NODE;
                end
            end

            S_DFS_NODE: begin
                n_dn      = stk_rdata[STK_W-1 -: IDX_W];
                n_dlen    = stk_rdata[CODE_W +: LEN_W];
                n_dcode   = stk_rdata[CODE_W-1:0];
                nod_raddr = stk_rdata[STK_W-1 -: IDX_W];
                n_state   = S_DFS_VISIT;
            end

            S_DFS_VISIT: begin
                if (r_dn < r_nleaf) begin
                    if (r_dlen > LEN_W'(MAX_CODE_LENGTH)) begin
                        n_too_long = 1'b1;
                    end
                    cod_we    = 1'b1;
                    cod_waddr = nod_rdata[NODE_W-1 -: SYM_W];
                    cod_wdata = {r_dcode, r_dlen};
                    cv_set    = 1'b1;
                    cv_idx    = nod_rdata[NODE_W-1 -: SYM_W];
                    n_state   = S_DFS_POP;
                end else begin
                    stk_we    = 1'b1;
                    stk_waddr = r_sp;
                    stk_wdata = {nod_rdata[IDX_W-1:0], r_dlen + LEN_W'(1),
                                 {r_dcode[CODE_W-2:0], 1'b1}};
                    n_sp      = r_sp + IDX_W'(1);
                    n_dn      = nod_rdata[2*IDX_W-1:IDX_W];
                    n_state   = S_DFS_PUSHL;
                end
            end

            S_DFS_PUSHL: begin
                stk_we    = 1'b1;
                stk_waddr = r_sp;
                stk_wdata = {r_dn, r_dlen + LEN_W'(1), {r_dcode[CODE_W-2:0], 1'b0}};
                n_sp      = r_sp + IDX_W'(1);
                n_state   = S_DFS_POP;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_code_value     = r_out_cval;
    assign o_code_length    = r_out_clen;
    assign o_decoded_symbol = r_out_dsym;
    assign o_symbol_valid   = r_out_dval;
    assign o_status         = r_out_stat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_heap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IDX_W'(HEAP_DEPTH))
        else $error("heap count exceeds the heap depth");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_ready)) |=>
            (r_state == S_IDLE && r_out_valid))
        else $error("finished item was not moved to the output register");

    a_cursor_internal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_tree && !r_root_leaf) |-> (r_cursor >= r_nleaf))
        else $error("decode cursor rests on a leaf");

    a_leaf_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dval) |-> (r_out_stat == ST_OK))
        else $error("decoded symbol flagged with an error status");

endmodule
